@@ src/ffha_pkg.sv @@
// Package for the first-fit heap allocator: sizes, header memory layout,
// transfer payload structs and the sequencer state type.
// Depends on nothing.
`default_nettype none

package ffha_pkg;

    // Heap geometry.
    localparam int HEAP_BYTES   = 65536;
    localparam int HEADER_BYTES = 24;
    localparam int MIN_PAYLOAD  = 16;
    localparam int SPLIT_MIN    = HEADER_BYTES + MIN_PAYLOAD;

    // Block starts fall on this grain, so headers are stored by start / GRAIN.
    localparam int GRAIN        = 8;
    localparam int GRAIN_W      = $clog2(GRAIN);

    // Widths: byte addresses include the heap end itself.
    localparam int BADDR_W      = $clog2(HEAP_BYTES) + 1;
    localparam int IDX_W        = $clog2(HEAP_BYTES / GRAIN);
    localparam int HDR_DEPTH    = HEAP_BYTES / GRAIN;
    localparam int SIZE_W       = 16;
    localparam int ENTRY_W      = SIZE_W + 1;
    localparam int STAT_W       = 17;
    localparam int LIVE_W       = 11;

    // Commands.
    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef struct packed {
        logic        command;
        logic [15:0] request_size;
        logic [15:0] payload_offset;
    } t_in;

    typedef struct packed {
        logic              ok;
        logic [15:0]       granted_offset;
        logic [STAT_W-1:0] bytes_used;
        logic [STAT_W-1:0] bytes_free;
        logic [LIVE_W-1:0] live_blocks;
    } t_out;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CHECK,
        ST_SPLIT,
        ST_MERGE,
        ST_FINISH
    } t_state;

endpackage

`default_nettype wire

@@ src/first_fit_heap_allocator.sv @@
// First-fit heap allocator top level: header memory, chain walker and
// statistics. Depends on ffha_pkg and ffha_ram.
`default_nettype none

//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------
//  in      | input     | i_in_valid / o_in_stall | i_in_data  (t_in)
//  out     | output    | o_out_valid/ i_out_stall| o_out_data (t_out)
//
// Headers are stored in one RAM indexed by block start / 8. An item is accepted
// with a read of the first header, walks the chain with one RAM read per block
// visited, writes back the changed headers and then loads the result register.
// After reset the initial free block is written before the first transfer.
// A result waits in the output register while the output is stalled; the walker
// holds in its finish step until that register is free.

module first_fit_heap_allocator (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output      logic            o_in_stall,
    input  wire ffha_pkg::t_in   i_in_data,
    output      logic            o_out_valid,
    input  wire logic            i_out_stall,
    output      ffha_pkg::t_out  o_out_data
);
    import ffha_pkg::*;

    t_state r_state, n_state;

    // Item registers.
    logic                r_cmd;
    logic [STAT_W-1:0]   r_s;
    logic [15:0]         r_off;
    logic [IDX_W-1:0]    r_idx;
    logic [IDX_W-1:0]    r_idx2;
    logic [SIZE_W-1:0]   r_rem;
    logic [IDX_W-1:0]    r_prev_idx;
    logic                r_prev_free;
    logic [SIZE_W-1:0]   r_prev_size;
    logic [SIZE_W-1:0]   r_tgt_size;
    logic                r_has_next;
    logic                r_res_ok;
    logic [15:0]         r_res_off;

    // Statistics.
    logic [STAT_W-1:0]   r_used;
    logic [STAT_W-1:0]   r_free;
    logic [LIVE_W-1:0]   r_live;

    // Output register.
    logic                r_out_valid;
    t_out                r_out;

    // RAM port signals.
    logic                mem_we, mem_re;
    logic [IDX_W-1:0]    mem_waddr, mem_raddr;
    logic [ENTRY_W-1:0]  mem_wdata, mem_rdata;

    ffha_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (HDR_DEPTH)
    ) u_hdr_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Decode of the header just read and the block it describes.
    logic                in_accept;
    logic                out_free;
    logic                d_free;
    logic [SIZE_W-1:0]   d_size;
    logic [BADDR_W-1:0]  blk_b, pay_b, next_b;
    logic                at_end, fit, split, hit, past;
    logic [BADDR_W-1:0]  split_b;
    logic [STAT_W-1:0]   round_s;
    logic                next_free;
    logic [IDX_W-1:0]    merge_idx;
    logic [STAT_W-1:0]   merge_size;
    logic [STAT_W-1:0]   merge_credit;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign d_free    = mem_rdata[SIZE_W];
    assign d_size    = mem_rdata[SIZE_W-1:0];
    assign blk_b     = BADDR_W'({r_idx, {GRAIN_W{1'b0}}});
    assign pay_b     = blk_b + BADDR_W'(HEADER_BYTES);
    assign next_b    = pay_b + BADDR_W'(d_size);
    assign at_end    = next_b >= BADDR_W'(HEAP_BYTES);
    assign fit       = d_free && (STAT_W'(d_size) >= r_s);
    assign split     = STAT_W'(d_size) >= r_s + STAT_W'(SPLIT_MIN);
    assign split_b   = pay_b + BADDR_W'(r_s);
    assign hit       = pay_b == BADDR_W'(r_off);
    assign past      = pay_b > BADDR_W'(r_off);
    assign round_s   = (STAT_W'(i_in_data.request_size) + STAT_W'(MIN_PAYLOAD - 1))
                       & ~STAT_W'(MIN_PAYLOAD - 1);

    // Merge of the released block with free neighbors.
    assign next_free    = r_has_next && d_free;
    assign merge_idx    = r_prev_free ? r_prev_idx : r_idx;
    assign merge_size   = STAT_W'(r_tgt_size)
                        + (r_prev_free ? STAT_W'(r_prev_size) + STAT_W'(HEADER_BYTES)
                                       : '0)
                        + (next_free ? STAT_W'(d_size) + STAT_W'(HEADER_BYTES) : '0);
    assign merge_credit = (r_prev_free ? STAT_W'(HEADER_BYTES) : '0)
                        + (next_free ? STAT_W'(HEADER_BYTES) : '0);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT: begin
                n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_accept) begin
                    if (i_in_data.command == CMD_ALLOC) begin
                        n_state = (i_in_data.request_size == '0) ? ST_FINISH : ST_CHECK;
                    end else begin
                        n_state = (i_in_data.payload_offset == '0) ? ST_FINISH : ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (r_cmd == CMD_ALLOC) begin
                    if (fit) begin
                        n_state = split ? ST_SPLIT : ST_FINISH;
                    end else if (at_end) begin
                        n_state = ST_FINISH;
                    end
                end else begin
                    if (hit && !d_free) begin
                        n_state = ST_MERGE;
                    end else if (hit || past || at_end) begin
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_SPLIT: begin
                n_state = ST_FINISH;
            end
            ST_MERGE: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase
    end

    // Handshake and RAM controls.
    always_comb begin
        o_in_stall = (r_state != ST_IDLE);
        mem_we     = 1'b0;
        mem_waddr  = r_idx;
        mem_wdata  = '0;
        mem_re     = 1'b0;
        mem_raddr  = next_b[IDX_W+GRAIN_W-1:GRAIN_W];
        unique case (r_state)
            ST_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = {1'b1, SIZE_W'(HEAP_BYTES - HEADER_BYTES)};
            end
            ST_IDLE: begin
                mem_re    = in_accept;
                mem_raddr = '0;
            end
            ST_CHECK: begin
                if (r_cmd == CMD_ALLOC) begin
                    if (fit) begin
                        mem_we    = 1'b1;
                        mem_wdata = {1'b0, split ? r_s[SIZE_W-1:0] : d_size};
                    end else begin
                        mem_re = !at_end;
                    end
                end else begin
                    mem_re = !at_end && ((hit && !d_free) || (!hit && !past));
                end
            end
            ST_SPLIT: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx2;
                mem_wdata = {1'b1, r_rem};
            end
            ST_MERGE: begin
                mem_we    = 1'b1;
                mem_waddr = merge_idx;
                mem_wdata = {1'b1, merge_size[SIZE_W-1:0]};
            end
            ST_FINISH: begin
            end
            default: begin
            end
        endcase
    end

    // State and statistics registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_used      <= '0;
            r_free      <= STAT_W'(HEAP_BYTES - HEADER_BYTES);
            r_live      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_out_valid && !i_out_stall && r_state != ST_FINISH) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_CHECK: begin
                    if (r_cmd == CMD_ALLOC && fit) begin
                        r_live <= r_live + LIVE_W'(1);
                        if (split) begin
                            r_used <= r_used + r_s + STAT_W'(HEADER_BYTES);
                            r_free <= r_free - r_s - STAT_W'(HEADER_BYTES);
                        end else begin
                            r_used <= r_used + STAT_W'(d_size) + STAT_W'(HEADER_BYTES);
                            r_free <= r_free - STAT_W'(d_size);
                        end
                    end else if (r_cmd == CMD_RELEASE && hit && !d_free) begin
                        r_live <= r_live - LIVE_W'(1);
                        r_used <= r_used - STAT_W'(d_size) - STAT_W'(HEADER_BYTES);
                        r_free <= r_free + STAT_W'(d_size);
                    end
                end
                ST_MERGE: begin
                    r_free <= r_free + merge_credit;
                end
                ST_FINISH: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Item datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    r_cmd       <= i_in_data.command;
                    r_s         <= round_s;
                    r_off       <= i_in_data.payload_offset;
                    r_idx       <= '0;
                    r_prev_free <= 1'b0;
                    r_res_ok    <= 1'b0;
                    r_res_off   <= '0;
                end
            end
            ST_CHECK: begin
                if (r_cmd == CMD_ALLOC && fit) begin
                    r_res_ok  <= 1'b1;
                    r_res_off <= pay_b[15:0];
                    r_idx2    <= split_b[IDX_W+GRAIN_W-1:GRAIN_W];
                    r_rem     <= SIZE_W'(STAT_W'(d_size) - r_s - STAT_W'(HEADER_BYTES));
                end else if (r_cmd == CMD_RELEASE && hit && !d_free) begin
                    r_res_ok   <= 1'b1;
                    r_tgt_size <= d_size;
                    r_has_next <= !at_end;
                end else begin
                    // Step to the next block on the chain.
                    r_idx       <= next_b[IDX_W+GRAIN_W-1:GRAIN_W];
                    r_prev_idx  <= r_idx;
                    r_prev_free <= d_free;
                    r_prev_size <= d_size;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    r_out.ok             <= r_res_ok;
                    r_out.granted_offset <= r_res_off;
                    r_out.bytes_used     <= r_used;
                    r_out.bytes_free     <= r_free;
                    r_out.live_blocks    <= r_live;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

@@ src/ffha_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
`default_nettype none

module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire
